// File: hw/rtl/tdag_pkg.sv
// Shared types and constants for the tensor diagonal address generator.
`timescale 1ns / 1ps
package tdag_pkg;

  localparam int MAX_RANK    = 4;
  localparam int DIM_BITS    = 16;
  localparam int IDX_W       = 48;
  localparam int W_W         = IDX_W - DIM_BITS;
  localparam int RANK_W      = 3;
  localparam int AX_W        = 3;
  localparam int OFF_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int RIDX_W      = $clog2(MAX_RANK);
  localparam int STEPS       = 4;
  localparam int DIV1_STAGES = W_W / STEPS;
  localparam int DIV2_STAGES = DIM_BITS / STEPS;
  localparam int NUM_DIV     = DIV1_STAGES + DIV2_STAGES;
  localparam int OK_STAGE    = 3;
  localparam int ADDR_STAGES = 5;
  localparam int PIPE_LAT    = 1 + NUM_DIV + ADDR_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_RANK  = 3'd0,
    REG_DIM_SIZE_0  = 3'd1,
    REG_DIM_SIZE_1  = 3'd2,
    REG_DIM_SIZE_2  = 3'd3,
    REG_DIM_SIZE_3  = 3'd4,
    REG_FIRST_AXIS  = 3'd5,
    REG_SECOND_AXIS = 3'd6,
    REG_DIAG_OFFSET = 3'd7
  } cfg_reg_t;

  // Which coordinate feeds a source dimension.
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_AX1,
    SEL_AX2,
    SEL_HI,
    SEL_MID
  } coord_sel_t;

  typedef struct packed {
    logic                vld;
    logic                ok;
    logic [DIM_BITS-1:0] rem;
    logic [W_W-1:0]      w;
    logic [DIM_BITS-1:0] diag;
  } div_pipe_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]                  o1;
    logic [DIM_BITS-1:0]                  o2;
    logic [IDX_W-1:0]                     cnt;
    logic [DIM_BITS-1:0]                  pos_off;
    logic [DIM_BITS-1:0]                  neg_off;
    coord_sel_t [MAX_RANK-1:0]            sel;
    logic [MAX_RANK-1:0][IDX_W-1:0]       stride;
  } cfg_drv_t;

endpackage

// File: hw/rtl/tdag_cfg.sv
// Configuration registers and derived view shape, count and strides.
`timescale 1ns / 1ps
module tdag_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tdag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tdag_pkg::cfg_drv_t              drv
);
  import tdag_pkg::*;

  logic [RANK_W-1:0]   rank_cfg_r;
  logic [DIM_BITS-1:0] dim_r [MAX_RANK];
  logic [AX_W-1:0]     ax1_r;
  logic [AX_W-1:0]     ax2_r;
  logic [OFF_W-1:0]    off_r;

  logic [RANK_W-1:0]        rank_c;
  logic signed [AX_W:0]     rank_s;
  logic signed [AX_W:0]     a1s;
  logic signed [AX_W:0]     a2s;
  logic signed [AX_W:0]     a1n;
  logic signed [AX_W:0]     a2n;
  logic [RIDX_W-1:0]        a1i;
  logic [RIDX_W-1:0]        a2i;
  logic                     bad_c;
  logic [DIM_BITS-1:0]      d1;
  logic [DIM_BITS-1:0]      d2;
  logic                     off_neg;
  logic [DIM_BITS-1:0]      pmag;
  logic [OFF_W-1:0]         qmag;
  logic [DIM_BITS-1:0]      span;
  logic [DIM_BITS-1:0]      len_c;
  logic [DIM_BITS-1:0]      first_d;
  logic [DIM_BITS-1:0]      last_d;
  logic                     found;
  logic [RANK_W-1:0]        m_cnt;
  logic [RIDX_W-1:0]        k_cnt;
  coord_sel_t [MAX_RANK-1:0] sel_c;

  // First derived stage
  logic [RANK_W-1:0]         rank_r;
  logic                      bad_r;
  logic [DIM_BITS-1:0]       o0_r;
  logic [DIM_BITS-1:0]       o1_r;
  logic [DIM_BITS-1:0]       o2_r;
  logic [DIM_BITS-1:0]       pos_off_r;
  logic [DIM_BITS-1:0]       neg_off_r;
  coord_sel_t [MAX_RANK-1:0] sel_r;
  logic [2*DIM_BITS-1:0]     p12_r;
  logic [2*DIM_BITS-1:0]     p23_r;
  // Second derived stage
  logic [2*DIM_BITS-1:0]     cnt_part_r;
  logic [IDX_W-1:0]          p123_r;
  // Third derived stage
  logic [IDX_W-1:0]                 cnt_r;
  logic [MAX_RANK-1:0][IDX_W-1:0]   stride_r;
  logic [MAX_RANK-1:0][IDX_W-1:0]   stride_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_cfg_r <= RANK_W'(2);
      for (int i = 0; i < MAX_RANK; i++) begin
        dim_r[i] <= DIM_BITS'(1);
      end
      ax1_r <= AX_W'(0);
      ax2_r <= AX_W'(1);
      off_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_RANK:  rank_cfg_r <= cfg_wdata[RANK_W-1:0];
        REG_DIM_SIZE_0:  dim_r[0] <= cfg_wdata[DIM_BITS-1:0];
        REG_DIM_SIZE_1:  dim_r[1] <= cfg_wdata[DIM_BITS-1:0];
        REG_DIM_SIZE_2:  dim_r[2] <= cfg_wdata[DIM_BITS-1:0];
        REG_DIM_SIZE_3:  dim_r[3] <= cfg_wdata[DIM_BITS-1:0];
        REG_FIRST_AXIS:  ax1_r <= cfg_wdata[AX_W-1:0];
        REG_SECOND_AXIS: ax2_r <= cfg_wdata[AX_W-1:0];
        REG_DIAG_OFFSET: off_r <= cfg_wdata[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Rank clamp and axis normalization
  always_comb begin
    rank_c = rank_cfg_r;
    if (rank_cfg_r < RANK_W'(2)) begin
      rank_c = RANK_W'(2);
    end else if (rank_cfg_r > RANK_W'(MAX_RANK)) begin
      rank_c = RANK_W'(MAX_RANK);
    end
    rank_s = signed'({1'b0, rank_c});
    a1s    = signed'({ax1_r[AX_W-1], ax1_r});
    a2s    = signed'({ax2_r[AX_W-1], ax2_r});
    a1n    = a1s[AX_W] ? a1s + rank_s : a1s;
    a2n    = a2s[AX_W] ? a2s + rank_s : a2s;
    bad_c  = a1n[AX_W] || a2n[AX_W] || (a1n >= rank_s) || (a2n >= rank_s) || (a1n == a2n);
    a1i    = a1n[RIDX_W-1:0];
    a2i    = a2n[RIDX_W-1:0];
  end

  always_comb begin
    d1 = '0;
    d2 = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      if (a1i == RIDX_W'(i)) d1 = dim_r[i];
      if (a2i == RIDX_W'(i)) d2 = dim_r[i];
    end
  end

  // Diagonal length
  always_comb begin
    off_neg = off_r[OFF_W-1];
    pmag    = off_r[DIM_BITS-1:0];
    qmag    = ~off_r + OFF_W'(1);
    span    = '0;
    len_c   = '0;
    if (!off_neg) begin
      if (pmag < d2) begin
        span  = d2 - pmag;
        len_c = (d1 < span) ? d1 : span;
      end
    end else begin
      if (qmag < {1'b0, d1}) begin
        span  = d1 - qmag[DIM_BITS-1:0];
        len_c = (span < d2) ? span : d2;
      end
    end
  end

  // Remaining dims in order; the outer two view radices are 1 when absent.
  always_comb begin
    first_d = DIM_BITS'(1);
    last_d  = DIM_BITS'(1);
    found   = 1'b0;
    m_cnt   = '0;
    k_cnt   = '0;
    for (int i = 0; i < MAX_RANK; i++) begin
      if (RANK_W'(i) < rank_c && RIDX_W'(i) != a1i && RIDX_W'(i) != a2i) begin
        if (!found) first_d = dim_r[i];
        found  = 1'b1;
        last_d = dim_r[i];
        m_cnt  = m_cnt + RANK_W'(1);
      end
    end
    for (int i = 0; i < MAX_RANK; i++) begin
      if (RANK_W'(i) >= rank_c) begin
        sel_c[i] = SEL_NONE;
      end else if (RIDX_W'(i) == a1i) begin
        sel_c[i] = SEL_AX1;
      end else if (RIDX_W'(i) == a2i) begin
        sel_c[i] = SEL_AX2;
      end else begin
        sel_c[i] = (m_cnt == RANK_W'(2) && k_cnt == '0) ? SEL_HI : SEL_MID;
        k_cnt    = k_cnt + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rank_r    <= rank_c;
    bad_r     <= bad_c;
    o0_r      <= (m_cnt == RANK_W'(2)) ? first_d : DIM_BITS'(1);
    o1_r      <= (m_cnt == '0) ? DIM_BITS'(1) : last_d;
    o2_r      <= len_c;
    pos_off_r <= off_neg ? '0 : pmag;
    neg_off_r <= off_neg ? qmag[DIM_BITS-1:0] : '0;
    sel_r     <= sel_c;
    p12_r     <= dim_r[1] * dim_r[2];
    p23_r     <= dim_r[2] * dim_r[3];
  end

  always_ff @(posedge clk) begin
    cnt_part_r <= o0_r * o1_r;
    p123_r     <= {{DIM_BITS{1'b0}}, p23_r} * dim_r[1];
  end

  always_comb begin
    stride_nxt = '0;
    unique case (rank_r)
      RANK_W'(4): begin
        stride_nxt[0] = p123_r;
        stride_nxt[1] = IDX_W'(p23_r);
        stride_nxt[2] = IDX_W'(dim_r[3]);
        stride_nxt[3] = IDX_W'(1);
      end
      RANK_W'(3): begin
        stride_nxt[0] = IDX_W'(p12_r);
        stride_nxt[1] = IDX_W'(dim_r[2]);
        stride_nxt[2] = IDX_W'(1);
      end
      default: begin
        stride_nxt[0] = IDX_W'(dim_r[1]);
        stride_nxt[1] = IDX_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r    <= bad_r ? '0 : {{DIM_BITS{1'b0}}, cnt_part_r} * o2_r;
    stride_r <= stride_nxt;
  end

  always_comb begin
    drv.o1      = o1_r;
    drv.o2      = o2_r;
    drv.cnt     = cnt_r;
    drv.pos_off = pos_off_r;
    drv.neg_off = neg_off_r;
    drv.sel     = sel_r;
    drv.stride  = stride_r;
  end

endmodule

// File: hw/rtl/tdag_div_stage.sv
// One divider pipeline stage: four restoring quotient bits per clock.
`timescale 1ns / 1ps
module tdag_div_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdag_pkg::div_pipe_t           stage_in,
  input  logic [tdag_pkg::DIM_BITS-1:0] divisor,
  output tdag_pkg::div_pipe_t           stage_out
);
  import tdag_pkg::*;

  logic [DIM_BITS-1:0] r;
  logic [W_W-1:0]      w;
  logic [DIM_BITS:0]   t;
  div_pipe_t           stage_nxt;
  div_pipe_t           stage_r;

  always_comb begin
    r = stage_in.rem;
    w = stage_in.w;
    t = '0;
    for (int s = 0; s < STEPS; s++) begin
      t = {r, w[W_W-1]};
      w = {w[W_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        w[0] = 1'b1;
      end
      r = t[DIM_BITS-1:0];
    end
    stage_nxt     = stage_in;
    stage_nxt.rem = r;
    stage_nxt.w   = w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

// File: hw/rtl/tdag_addr.sv
// Coordinate mapping and stride multiply-accumulate to the source offset.
`timescale 1ns / 1ps
module tdag_addr (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tdag_pkg::div_pipe_t        coord_in,
  input  tdag_pkg::cfg_drv_t         drv,
  output logic                       out_strobe,
  output logic [tdag_pkg::IDX_W-1:0] out_source_offset,
  output logic                       out_index_valid
);
  import tdag_pkg::*;

  logic [ADDR_STAGES-2:0]   vld_r;
  logic [ADDR_STAGES-2:0]   ok_r;
  logic [DIM_BITS-1:0]      ic_nxt  [MAX_RANK];
  logic [DIM_BITS-1:0]      ic_r    [MAX_RANK];
  logic [IDX_W-1:0]         plo_r   [MAX_RANK];
  logic [2*DIM_BITS-1:0]    phigh_full[MAX_RANK];
  logic [DIM_BITS-1:0]      phigh_r [MAX_RANK];
  logic [IDX_W-1:0]         term_r  [MAX_RANK];
  logic [IDX_W-1:0]         pair_r  [MAX_RANK/2];
  logic                     strobe_r;
  logic                     valid_r;
  logic [IDX_W-1:0]         offset_r;

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      unique case (drv.sel[i])
        SEL_AX1: ic_nxt[i] = coord_in.diag + drv.neg_off;
        SEL_AX2: ic_nxt[i] = coord_in.diag + drv.pos_off;
        SEL_HI:  ic_nxt[i] = coord_in.w[DIM_BITS-1:0];
        SEL_MID: ic_nxt[i] = coord_in.rem;
        default: ic_nxt[i] = '0;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      phigh_full[i] = ic_r[i] * drv.stride[i][IDX_W-1:W_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      strobe_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      vld_r    <= {vld_r[ADDR_STAGES-3:0], coord_in.vld};
      strobe_r <= vld_r[ADDR_STAGES-2];
      valid_r  <= vld_r[ADDR_STAGES-2] & ok_r[ADDR_STAGES-2];
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= {ok_r[ADDR_STAGES-3:0], coord_in.ok};
    for (int i = 0; i < MAX_RANK; i++) begin
      ic_r[i]    <= ic_nxt[i];
      plo_r[i]   <= {{DIM_BITS{1'b0}}, ic_r[i]} * drv.stride[i][W_W-1:0];
      phigh_r[i] <= phigh_full[i][DIM_BITS-1:0];
      term_r[i]  <= plo_r[i] + {phigh_r[i], {W_W{1'b0}}};
    end
    for (int j = 0; j < MAX_RANK/2; j++) begin
      pair_r[j] <= term_r[2*j] + term_r[2*j+1];
    end
    offset_r <= ok_r[ADDR_STAGES-2] ? pair_r[0] + pair_r[1] : '0;
  end

  assign out_strobe        = strobe_r;
  assign out_index_valid   = valid_r;
  assign out_source_offset = offset_r;

endmodule

// File: hw/rtl/tensor_diagonal_address_gen.sv
// Top level of the tensor diagonal address generator.
//
//   Channel  Ports                                          Handshake
//   input    start, busy, in_out_index                      start & !busy
//   result   out_strobe, out_source_offset, out_index_valid one-cycle strobe
//   config   cfg_we, cfg_index, cfg_wdata                   write on cfg_we
//
// One request per clock while busy is low.
// The pipeline is the input register, twelve divider stages (two chained
// mixed-radix divisions, four quotient bits per stage) and five stages of
// coordinate select, stride multiply and adder tree.
// busy is a registered copy of reset: high during reset, it falls at the clock edge after reset is released.
// Results cannot be held off.
// Config-derived values settle after a write once the derived stages in tdag_cfg have been updated.
`timescale 1ns / 1ps
module tensor_diagonal_address_gen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [tdag_pkg::IDX_W-1:0]      in_out_index,
  output logic                            out_strobe,
  output logic [tdag_pkg::IDX_W-1:0]      out_source_offset,
  output logic                            out_index_valid,
  input  logic                            cfg_we,
  input  logic [tdag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdag_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tdag_pkg::*;

  cfg_drv_t         drv;
  logic             busy_r;
  logic             accept;
  logic             s0_vld_r;
  logic [IDX_W-1:0] s0_idx_r;
  logic [IDX_W-1:0] idx1_r;
  logic [IDX_W-1:0] idx2_r;
  logic             in_range;
  div_pipe_t        stg [NUM_DIV+1];

  tdag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .drv       (drv)
  );

  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_idx_r <= in_out_index;
    idx1_r   <= s0_idx_r;
    idx2_r   <= idx1_r;
  end

  assign in_range = idx2_r < drv.cnt;

  assign stg[0] = '{vld:  s0_vld_r,
                    ok:   1'b0,
                    rem:  s0_idx_r[IDX_W-1:W_W],
                    w:    s0_idx_r[W_W-1:0],
                    diag: '0};

  for (genvar k = 1; k <= NUM_DIV; k++) begin : g_div
    div_pipe_t           sin;
    logic [DIM_BITS-1:0] dv;

    if (k == OK_STAGE) begin : g_ok
      always_comb begin
        sin    = stg[k-1];
        sin.ok = in_range;
      end
    end else if (k == DIV1_STAGES + 1) begin : g_hand
      // Quotient of the first division becomes the second dividend.
      always_comb begin
        sin      = stg[k-1];
        sin.rem  = stg[k-1].w[W_W-1:W_W-DIM_BITS];
        sin.w    = {stg[k-1].w[W_W-DIM_BITS-1:0], {DIM_BITS{1'b0}}};
        sin.diag = stg[k-1].rem;
      end
    end else begin : g_pass
      assign sin = stg[k-1];
    end

    assign dv = (k <= DIV1_STAGES) ? drv.o2 : drv.o1;

    tdag_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (sin),
      .divisor   (dv),
      .stage_out (stg[k])
    );
  end

  tdag_addr u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .coord_in          (stg[NUM_DIV]),
    .drv               (drv),
    .out_strobe        (out_strobe),
    .out_source_offset (out_source_offset),
    .out_index_valid   (out_index_valid)
  );

endmodule

// File: hw/rtl/tdag_checker.sv
// Port-level assertions for the tensor diagonal address generator.
`timescale 1ns / 1ps
module tdag_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input logic [tdag_pkg::IDX_W-1:0] out_source_offset,
  input logic                       out_index_valid
);
  import tdag_pkg::*;

  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_index_valid) |-> (out_source_offset == '0))
    else $error("out-of-range result has nonzero offset");

  a_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_index_valid |-> out_strobe)
    else $error("index_valid outside a result");

  a_busy_reset: assert property (@(posedge clk)
    busy |-> $past(!rst_n))
    else $error("busy outside reset");

endmodule

bind tensor_diagonal_address_gen tdag_checker u_tdag_checker (.*);
